>>> hw/rtl/icymd_pkg.sv
// ----------------------------------------------------------------------------
// icymd_pkg
// Shared types, codes and key tables of the inline metadata deframer.
// ----------------------------------------------------------------------------
package icymd_pkg;

    localparam int DEF_MAX_BLOCK_BYTES = 4096;
    localparam int DEF_INTERVAL_BITS   = 24;
    localparam int DEF_META_INTERVAL   = 16000;
    localparam int OUTQ_DEPTH          = 8;

    // result kinds
    localparam logic [2:0] K_AUDIO      = 3'd0;
    localparam logic [2:0] K_TITLE      = 3'd1;
    localparam logic [2:0] K_URL        = 3'd2;
    localparam logic [2:0] K_TITLE_DONE = 3'd3;
    localparam logic [2:0] K_URL_DONE   = 3'd4;
    localparam logic [2:0] K_END        = 3'd5;

    // byte classes seen by the framer
    localparam logic [1:0] CLS_AUDIO = 2'd0;
    localparam logic [1:0] CLS_LEN   = 2'd1;
    localparam logic [1:0] CLS_DATA  = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    localparam logic [3:0] TITLE_KEY_LEN = 4'd13;
    localparam logic [3:0] URL_KEY_LEN   = 4'd11;
    // first position where the two keys part ("StreamT" vs "StreamU")
    localparam logic [3:0] URL_FORK_POS  = 4'd6;

    typedef struct packed {
        logic [1:0] cls;
        logic [7:0] data;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       updated;
        logic       last;
    } res_t;

    function automatic res_t make_res(input logic [2:0] kind, input logic [7:0] value,
                                      input logic updated);
        res_t r;
        r.kind    = kind;
        r.value   = value;
        r.updated = updated;
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] title_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "S";
            4'd1:    ch = "t";
            4'd2:    ch = "r";
            4'd3:    ch = "e";
            4'd4:    ch = "a";
            4'd5:    ch = "m";
            4'd6:    ch = "T";
            4'd7:    ch = "i";
            4'd8:    ch = "t";
            4'd9:    ch = "l";
            4'd10:   ch = "e";
            4'd11:   ch = "=";
            4'd12:   ch = CH_QUOTE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] url_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "S";
            4'd1:    ch = "t";
            4'd2:    ch = "r";
            4'd3:    ch = "e";
            4'd4:    ch = "a";
            4'd5:    ch = "m";
            4'd6:    ch = "U";
            4'd7:    ch = "r";
            4'd8:    ch = "l";
            4'd9:    ch = "=";
            4'd10:   ch = CH_QUOTE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> hw/rtl/icy_metadata_deframer.sv
// ----------------------------------------------------------------------------
// icy_metadata_deframer
// Splits an ICY byte stream into audio bytes and StreamTitle / StreamUrl
// characters, with a block-end report of whether the metadata changed.
//
// Input channel s_*: one raw stream byte per request. Output channel m_*: one
// result per request (kind, value, updated, last); one byte gives zero, one
// or two results, the last of them flagged by m_last.
// An accepted byte is registered by the framer, then its results are written
// into the result queue. Throughput: one byte per cycle while s_ready is
// high; the output port moves one result per cycle, so bytes that make two
// results (a released quote plus a character) need two output transfers.
// The previous-block store is one memory, read at the accepting edge and
// written back at the next edge, with forwarding when consecutive bytes hit
// the same entry. Reset: synchronous; the interval returns to 16000 and the
// previous block reads as all zero at once through a fill count (no clearing
// pass). When m_ready stays low, an 8-entry result queue absorbs results
// and s_ready drops once it cannot promise room for a new byte and one in flight.
// ----------------------------------------------------------------------------
module icy_metadata_deframer #(
    parameter int MAX_BLOCK_BYTES = icymd_pkg::DEF_MAX_BLOCK_BYTES,
    parameter int INTERVAL_BITS   = icymd_pkg::DEF_INTERVAL_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [INTERVAL_BITS-1:0] cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_data_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_kind,
    output logic [7:0]               m_value,
    output logic                     m_updated,
    output logic                     m_last
);
    import icymd_pkg::*;

    localparam int AW = $clog2(MAX_BLOCK_BYTES);

    logic          accept;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          b_valid;
    item_t         b_item;
    logic [AW-1:0] b_addr;
    logic          mismatch;
    logic [1:0]    push_cnt;
    res_t          res0;
    res_t          res1;
    logic          room_ok;
    logic          q_valid;
    res_t          q_head;

    assign s_ready = aresetn && room_ok;
    assign accept  = s_valid && s_ready;

    icymd_framer #(
        .INTERVAL_BITS(INTERVAL_BITS),
        .AW           (AW)
    ) u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .data_byte  (s_data_byte),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .b_valid_reg(b_valid),
        .b_item_reg (b_item),
        .b_addr_reg (b_addr)
    );

    icymd_store #(
        .DEPTH(MAX_BLOCK_BYTES),
        .AW   (AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .b_valid (b_valid),
        .b_item  (b_item),
        .b_addr  (b_addr),
        .mismatch(mismatch)
    );

    icymd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .b_valid (b_valid),
        .b_item  (b_item),
        .mismatch(mismatch),
        .push_cnt(push_cnt),
        .res0    (res0),
        .res1    (res1)
    );

    icymd_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .res0     (res0),
        .res1     (res1),
        .b_pending(b_valid),
        .room_ok  (room_ok),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (m_valid && m_ready)
    );

    assign m_valid   = aresetn && q_valid;
    assign m_kind    = q_head.kind;
    assign m_value   = q_head.value;
    assign m_updated = q_head.updated;
    assign m_last    = q_head.last;

endmodule

>>> hw/rtl/icymd_framer.sv
// ----------------------------------------------------------------------------
// icymd_framer
// Audio counter and block framing; classifies each byte and issues the
// previous-block store read for each length and block byte.
// ----------------------------------------------------------------------------
module icymd_framer #(
    parameter int INTERVAL_BITS = 24,
    parameter int AW            = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [INTERVAL_BITS-1:0] cfg_wdata,
    input  logic                     accept,
    input  logic [7:0]               data_byte,
    output logic                     rd_en,
    output logic [AW-1:0]            rd_addr,
    output logic                     b_valid_reg,
    output icymd_pkg::item_t         b_item_reg,
    output logic [AW-1:0]            b_addr_reg
);
    import icymd_pkg::*;

    logic [INTERVAL_BITS-1:0] interval_reg;
    logic [INTERVAL_BITS-1:0] audio_count_reg, audio_count_next;
    logic                     in_block_reg, in_block_next;
    logic [7:0]               len_byte_reg, len_byte_next;
    logic [AW-1:0]            block_index_reg, block_index_next;
    item_t                    item;
    logic [AW-1:0]            addr;

    always_comb begin
        audio_count_next = audio_count_reg;
        in_block_next    = in_block_reg;
        len_byte_next    = len_byte_reg;
        block_index_next = block_index_reg;
        item.cls         = CLS_AUDIO;
        item.data        = data_byte;
        item.final_byte  = 1'b0;
        addr             = '0;
        if (!in_block_reg) begin
            if (audio_count_reg < interval_reg) begin
                if (accept) begin
                    audio_count_next = audio_count_reg + 1'b1;
                end
            end else begin
                item.cls = CLS_LEN;
                if (accept) begin
                    if (data_byte == 8'd0) begin
                        audio_count_next = '0;
                    end else begin
                        in_block_next    = 1'b1;
                        len_byte_next    = data_byte;
                        block_index_next = AW'(1);
                    end
                end
            end
        end else begin
            item.cls        = CLS_DATA;
            addr            = block_index_reg;
            item.final_byte = (block_index_reg >= AW'({len_byte_reg, 4'h0}));
            // the block's last byte always reads as zero
            if (item.final_byte) begin
                item.data = 8'd0;
            end
            if (accept) begin
                if (item.final_byte) begin
                    in_block_next    = 1'b0;
                    audio_count_next = '0;
                    len_byte_next    = 8'd0;
                    block_index_next = '0;
                end else begin
                    block_index_next = block_index_reg + 1'b1;
                end
            end
        end
    end

    assign rd_en   = accept && (item.cls != CLS_AUDIO);
    assign rd_addr = addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg    <= INTERVAL_BITS'(DEF_META_INTERVAL);
            audio_count_reg <= '0;
            in_block_reg    <= 1'b0;
            len_byte_reg    <= 8'd0;
            block_index_reg <= '0;
            b_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                interval_reg <= cfg_wdata;
            end
            audio_count_reg <= audio_count_next;
            in_block_reg    <= in_block_next;
            len_byte_reg    <= len_byte_next;
            block_index_reg <= block_index_next;
            b_valid_reg     <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_item_reg <= item;
            b_addr_reg <= addr;
        end
    end

endmodule

>>> hw/rtl/icymd_store.sv
// ----------------------------------------------------------------------------
// icymd_store
// Previous raw block memory: read ahead at the accepting edge, compare, write back.
// A fill count stands for the reset-to-zero contents.
// ----------------------------------------------------------------------------
module icymd_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             b_valid,
    input  icymd_pkg::item_t b_item,
    input  logic [AW-1:0]    b_addr,
    output logic             mismatch
);
    import icymd_pkg::*;

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rd_data_reg;
    logic [AW:0] fill_reg;
    logic        fwd_hit_reg;
    logic [7:0]  fwd_data_reg;
    logic        in_range;
    logic        wr_en;
    logic [7:0]  old_byte;
    logic [AW:0] addr_ext;

    assign addr_ext = {1'b0, b_addr};
    assign in_range = addr_ext < (AW+1)'(DEPTH);
    assign wr_en    = b_valid && (b_item.cls != CLS_AUDIO) && in_range;

    // entries at or above the fill count were never written: read as zero
    always_comb begin
        if (fwd_hit_reg) begin
            old_byte = fwd_data_reg;
        end else if (addr_ext < fill_reg) begin
            old_byte = rd_data_reg;
        end else begin
            old_byte = 8'd0;
        end
    end

    assign mismatch = in_range && (old_byte != b_item.data);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[b_addr] <= b_item.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        fwd_data_reg <= b_item.data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            if (wr_en && (addr_ext >= fill_reg)) begin
                fill_reg <= addr_ext + 1'b1;
            end
            // a read that races the write of the same entry takes the new byte
            if (rd_en) begin
                fwd_hit_reg <= wr_en && (rd_addr == b_addr);
            end
        end
    end

endmodule

>>> hw/rtl/icymd_parser.sv
// ----------------------------------------------------------------------------
// icymd_parser
// Field matcher and result builder; up to two results per byte.
// ----------------------------------------------------------------------------
module icymd_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             b_valid,
    input  icymd_pkg::item_t b_item,
    input  logic             mismatch,
    output logic [1:0]       push_cnt,
    output icymd_pkg::res_t  res0,
    output icymd_pkg::res_t  res1
);
    import icymd_pkg::*;

    localparam logic [2:0] M_PREFIX = 3'd0;
    localparam logic [2:0] M_URLPRE = 3'd1;
    localparam logic [2:0] M_SKIP   = 3'd2;
    localparam logic [2:0] M_TITLE  = 3'd3;
    localparam logic [2:0] M_URL    = 3'd4;
    localparam logic [2:0] M_STOP   = 3'd5;

    logic       differs_reg, differs_next;
    logic       field_seen_reg, field_seen_next;
    logic [2:0] mode_reg, mode_next;
    logic [3:0] pos_reg, pos_next;
    logic       quote_reg, quote_next;
    res_t       r [2];
    logic [1:0] n;
    logic [7:0] c;
    logic [2:0] chk_kind;
    logic [2:0] done_kind;

    assign c         = b_item.data;
    assign chk_kind  = (mode_reg == M_TITLE) ? K_TITLE : K_URL;
    assign done_kind = (mode_reg == M_TITLE) ? K_TITLE_DONE : K_URL_DONE;

    always_comb begin
        differs_next    = differs_reg;
        field_seen_next = field_seen_reg;
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        quote_next      = quote_reg;
        n               = 2'd0;
        r[0]            = '0;
        r[1]            = '0;
        if (b_valid) begin
            case (b_item.cls)
                CLS_AUDIO: begin
                    r[0] = make_res(K_AUDIO, c, 1'b0);
                    n    = 2'd1;
                end
                CLS_LEN: begin
                    differs_next    = mismatch;
                    field_seen_next = 1'b0;
                    mode_next       = M_PREFIX;
                    pos_next        = 4'd0;
                    quote_next      = 1'b0;
                    if (c == 8'd0) begin
                        r[0]         = make_res(K_END, 8'd0, 1'b0);
                        n            = 2'd1;
                        differs_next = 1'b0;
                    end
                end
                CLS_DATA: begin
                    if (b_item.final_byte) begin
                        r[0] = make_res(K_END, 8'd0, (differs_reg | mismatch) & field_seen_reg);
                        n               = 2'd1;
                        differs_next    = 1'b0;
                        field_seen_next = 1'b0;
                        mode_next       = M_PREFIX;
                        pos_next        = 4'd0;
                        quote_next      = 1'b0;
                    end else begin
                        differs_next = differs_reg | mismatch;
                        if (mode_reg != M_STOP) begin
                            if (c == 8'd0) begin
                                // zero byte: stop parsing, drop any open field
                                mode_next  = M_STOP;
                                quote_next = 1'b0;
                            end else begin
                                case (mode_reg)
                                    M_PREFIX: begin
                                        if (pos_reg < TITLE_KEY_LEN && c == title_char(pos_reg)) begin
                                            pos_next = pos_reg + 1'b1;
                                            if (pos_reg == TITLE_KEY_LEN - 4'd1) begin
                                                mode_next  = M_TITLE;
                                                pos_next   = 4'd0;
                                                quote_next = 1'b0;
                                            end
                                        end else if (pos_reg == URL_FORK_POS &&
                                                     c == url_char(URL_FORK_POS)) begin
                                            pos_next  = URL_FORK_POS + 4'd1;
                                            mode_next = M_URLPRE;
                                        end else begin
                                            pos_next = 4'd0;
                                            if (c == CH_SEMI) begin
                                                field_seen_next = 1'b1;
                                                mode_next       = M_PREFIX;
                                            end else begin
                                                mode_next = M_SKIP;
                                            end
                                        end
                                    end
                                    M_URLPRE: begin
                                        if (pos_reg < URL_KEY_LEN && c == url_char(pos_reg)) begin
                                            pos_next = pos_reg + 1'b1;
                                            if (pos_reg == URL_KEY_LEN - 4'd1) begin
                                                mode_next  = M_URL;
                                                pos_next   = 4'd0;
                                                quote_next = 1'b0;
                                            end
                                        end else begin
                                            pos_next = 4'd0;
                                            if (c == CH_SEMI) begin
                                                field_seen_next = 1'b1;
                                                mode_next       = M_PREFIX;
                                            end else begin
                                                mode_next = M_SKIP;
                                            end
                                        end
                                    end
                                    M_SKIP: begin
                                        if (c == CH_SEMI) begin
                                            field_seen_next = 1'b1;
                                            mode_next       = M_PREFIX;
                                            pos_next        = 4'd0;
                                            quote_next      = 1'b0;
                                        end
                                    end
                                    M_TITLE, M_URL: begin
                                        if (c == CH_QUOTE) begin
                                            // hold the quote until we know it is not the closer
                                            if (quote_reg) begin
                                                r[0] = make_res(chk_kind, CH_QUOTE, 1'b0);
                                                n    = 2'd1;
                                            end
                                            quote_next = 1'b1;
                                        end else if (c == CH_SEMI && quote_reg) begin
                                            r[0]            = make_res(done_kind, 8'd0, 1'b0);
                                            n               = 2'd1;
                                            field_seen_next = 1'b1;
                                            mode_next       = M_PREFIX;
                                            pos_next        = 4'd0;
                                            quote_next      = 1'b0;
                                        end else begin
                                            if (quote_reg) begin
                                                r[0] = make_res(chk_kind, CH_QUOTE, 1'b0);
                                                r[1] = make_res(chk_kind, c, 1'b0);
                                                n    = 2'd2;
                                            end else begin
                                                r[0] = make_res(chk_kind, c, 1'b0);
                                                n    = 2'd1;
                                            end
                                            quote_next = 1'b0;
                                        end
                                    end
                                    default: begin
                                        mode_next = M_STOP;
                                    end
                                endcase
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (n != 2'd0) begin
            r[n[1]].last = 1'b1;
        end
    end

    assign push_cnt = n;
    assign res0     = r[0];
    assign res1     = r[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            differs_reg    <= 1'b0;
            field_seen_reg <= 1'b0;
            mode_reg       <= M_PREFIX;
            pos_reg        <= 4'd0;
            quote_reg      <= 1'b0;
        end else begin
            differs_reg    <= differs_next;
            field_seen_reg <= field_seen_next;
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            quote_reg      <= quote_next;
        end
    end

endmodule

>>> hw/rtl/icymd_outq.sv
// ----------------------------------------------------------------------------
// icymd_outq
// Result queue: two pushes, one pop per cycle; grants input room ahead.
// ----------------------------------------------------------------------------
module icymd_outq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [1:0]      push_cnt,
    input  icymd_pkg::res_t res0,
    input  icymd_pkg::res_t res1,
    input  logic            b_pending,
    output logic            room_ok,
    output logic            q_valid,
    output icymd_pkg::res_t q_head,
    input  logic            q_pop
);
    import icymd_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    res_t          q [OUTQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW:0]   claimed;

    // an item in flight may add two results, the next one two more
    assign claimed = {1'b0, count_reg} + (b_pending ? (CW+1)'(2) : '0);
    assign room_ok = claimed <= (CW+1)'(OUTQ_DEPTH - 2);
    assign q_valid = (count_reg != '0);
    assign q_head  = q[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2) begin
            q[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push_cnt);
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push_cnt) - CW'(q_pop);
        end
    end

endmodule

>>> hw/rtl/icymd_checker.sv
// ----------------------------------------------------------------------------
// icymd_checker
// Port-level checks of the deframer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module icymd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_kind,
    input logic [7:0] m_value,
    input logic       m_updated,
    input logic       m_last
);
    import icymd_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_value)
            && $stable(m_updated) && $stable(m_last))
        else $error("stalled result changed");

    a_upd_only_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != K_END |-> !m_updated)
        else $error("updated flag outside block end");

    a_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == K_TITLE_DONE || m_kind == K_URL_DONE || m_kind == K_END)
            |-> m_value == 8'd0)
        else $error("value on a marker result");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == K_END || m_kind == K_AUDIO || m_kind == K_TITLE_DONE
            || m_kind == K_URL_DONE) |-> m_last)
        else $error("single-result kind not marked last");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind <= K_END)
        else $error("unknown result kind");

endmodule

bind icy_metadata_deframer icymd_checker u_icymd_checker (.*);

>>> tb/sv/icy_metadata_deframer_chk.sv
// ----------------------------------------------------------------------------
// icy_metadata_deframer_chk
// Watches both channels of the ICY deframer and predicts every result from
// the accepted bytes and the interval writes. Each result leaving the block
// is compared with the oldest one predicted.
// ----------------------------------------------------------------------------
module icy_metadata_deframer_chk #(
    parameter int IW = icymd_pkg::DEF_INTERVAL_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [IW-1:0] cfg_wdata,
    input  logic          s_valid,
    input  logic          s_ready,
    input  logic [7:0]    s_data_byte,
    input  logic          m_valid,
    input  logic          m_ready,
    input  logic [2:0]    m_kind,
    input  logic [7:0]    m_value,
    input  logic          m_updated,
    input  logic          m_last,
    output int            mismatch_count,
    output int            deframed_left,
    output int            results_checked
);
    import icymd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PS_KEY,
        PS_URL_KEY,
        PS_SKIP,
        PS_TITLE,
        PS_URL,
        PS_STOP
    } parse_state_t;

    localparam logic [8*13-1:0] TITLE_KEY = "StreamTitle='";
    localparam logic [8*11-1:0] URL_KEY   = "StreamUrl='";

    logic [IW-1:0] interval;
    int unsigned   aud_cnt;
    logic          in_meta;
    int            blk_len;
    int            blk_idx;
    logic [7:0]    prev_raw [DEF_MAX_BLOCK_BYTES];
    logic          blk_changed;
    parse_state_t  pstate;
    int            key_pos;
    logic          quote_held;
    logic          field_closed;
    res_t          deframed_q [$];

    function automatic logic [7:0] key_char(input bit is_url, input int pos);
        if (is_url) begin
            return URL_KEY[8*(10-pos) +: 8];
        end
        return TITLE_KEY[8*(12-pos) +: 8];
    endfunction

    function automatic res_t mk_res(input logic [2:0] k, input logic [7:0] v, input logic u);
        res_t r;
        r.kind    = k;
        r.value   = v;
        r.updated = u;
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic void restart_field();
        pstate     = PS_KEY;
        key_pos    = 0;
        quote_held = 1'b0;
    endfunction

    // key broke off: a semicolon closes the field right here, else skip to one
    function automatic void abandon_field(input logic [7:0] c);
        key_pos = 0;
        if (c == CH_SEMI) begin
            field_closed = 1'b1;
            pstate       = PS_KEY;
        end else begin
            pstate = PS_SKIP;
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] c);
        res_t       outs [2];
        int         n;
        logic       fin;
        logic [7:0] eff;
        logic [2:0] chr_kind;
        logic [2:0] done_kind;
        n = 0;
        if (!in_meta) begin
            if (aud_cnt < interval) begin
                outs[n] = mk_res(K_AUDIO, c, 1'b0);
                n++;
                aud_cnt++;
            end else begin
                blk_changed  = (prev_raw[0] != c);
                prev_raw[0]  = c;
                field_closed = 1'b0;
                restart_field();
                if (c == 8'h00) begin
                    outs[n] = mk_res(K_END, 8'h00, 1'b0);
                    n++;
                    aud_cnt     = 0;
                    blk_changed = 1'b0;
                end else begin
                    in_meta = 1'b1;
                    blk_len = int'(c) * 16 + 1;
                    blk_idx = 1;
                end
            end
        end else begin
            fin = (blk_idx + 1 >= blk_len);
            eff = fin ? 8'h00 : c;
            if (prev_raw[blk_idx] != eff) begin
                blk_changed = 1'b1;
            end
            prev_raw[blk_idx] = eff;
            if (pstate != PS_STOP) begin
                if (eff == 8'h00) begin
                    pstate     = PS_STOP;
                    quote_held = 1'b0;
                end else begin
                    case (pstate)
                        PS_KEY: begin
                            if (key_pos < TITLE_KEY_LEN && eff == key_char(1'b0, key_pos)) begin
                                key_pos++;
                                if (key_pos == TITLE_KEY_LEN) begin
                                    pstate     = PS_TITLE;
                                    key_pos    = 0;
                                    quote_held = 1'b0;
                                end
                            end else if (key_pos == URL_FORK_POS
                                         && eff == key_char(1'b1, URL_FORK_POS)) begin
                                key_pos = URL_FORK_POS + 1;
                                pstate  = PS_URL_KEY;
                            end else begin
                                abandon_field(eff);
                            end
                        end
                        PS_URL_KEY: begin
                            if (key_pos < URL_KEY_LEN && eff == key_char(1'b1, key_pos)) begin
                                key_pos++;
                                if (key_pos == URL_KEY_LEN) begin
                                    pstate     = PS_URL;
                                    key_pos    = 0;
                                    quote_held = 1'b0;
                                end
                            end else begin
                                abandon_field(eff);
                            end
                        end
                        PS_SKIP: begin
                            if (eff == CH_SEMI) begin
                                field_closed = 1'b1;
                                restart_field();
                            end
                        end
                        PS_TITLE, PS_URL: begin
                            chr_kind  = (pstate == PS_TITLE) ? K_TITLE : K_URL;
                            done_kind = (pstate == PS_TITLE) ? K_TITLE_DONE : K_URL_DONE;
                            if (eff == CH_QUOTE) begin
                                // hold the quote until we know it is not the closer
                                if (quote_held) begin
                                    outs[n] = mk_res(chr_kind, CH_QUOTE, 1'b0);
                                    n++;
                                end
                                quote_held = 1'b1;
                            end else if (eff == CH_SEMI && quote_held) begin
                                outs[n] = mk_res(done_kind, 8'h00, 1'b0);
                                n++;
                                field_closed = 1'b1;
                                restart_field();
                            end else begin
                                if (quote_held) begin
                                    outs[n] = mk_res(chr_kind, CH_QUOTE, 1'b0);
                                    n++;
                                end
                                quote_held = 1'b0;
                                outs[n] = mk_res(chr_kind, eff, 1'b0);
                                n++;
                            end
                        end
                        default: pstate = PS_STOP;
                    endcase
                end
            end
            if (fin) begin
                outs[n] = mk_res(K_END, 8'h00, blk_changed && field_closed);
                n++;
                in_meta      = 1'b0;
                aud_cnt      = 0;
                blk_len      = 0;
                blk_idx      = 0;
                blk_changed  = 1'b0;
                field_closed = 1'b0;
                restart_field();
            end else begin
                blk_idx = (blk_idx + 1) & 12'hFFF;
            end
        end
        if (n > 0) begin
            outs[n-1].last = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            deframed_q.push_back(outs[k]);
        end
    endfunction

    always @(posedge aclk) begin : watch
        res_t got;
        res_t want;
        if (!aresetn) begin
            interval        = IW'(DEF_META_INTERVAL);
            aud_cnt         = 0;
            in_meta         = 1'b0;
            blk_len         = 0;
            blk_idx         = 0;
            blk_changed     = 1'b0;
            field_closed    = 1'b0;
            mismatch_count  = 0;
            results_checked = 0;
            restart_field();
            for (int k = 0; k < DEF_MAX_BLOCK_BYTES; k++) begin
                prev_raw[k] = 8'h00;
            end
            deframed_q.delete();
        end else begin
            if (cfg_we) begin
                interval = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                deframe_byte(s_data_byte);
            end
            if (m_valid && m_ready) begin
                got.kind    = m_kind;
                got.value   = m_value;
                got.updated = m_updated;
                got.last    = m_last;
                results_checked++;
                if (deframed_q.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: extra result kind %0d value %02h updated %0b last %0b",
                                 $time, got.kind, got.value, got.updated, got.last);
                    end
                    mismatch_count++;
                end else begin
                    want = deframed_q.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value
                        || got.updated !== want.updated || got.last !== want.last) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: mismatch exp kind %0d value %02h updated %0b last %0b",
                                     $time, want.kind, want.value, want.updated, want.last);
                            $display("%0t:          got kind %0d value %02h updated %0b last %0b",
                                     $time, got.kind, got.value, got.updated, got.last);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        deframed_left <= deframed_q.size();
    end

endmodule

>>> tb/sv/icy_metadata_deframer_tb.sv
// ----------------------------------------------------------------------------
// icy_metadata_deframer_tb
// Drives the ICY deframer with audio runs and metadata blocks: a directed
// opening on interval corner cases and quote handling, then random blocks of
// title, URL and other fields mixed with noise and repeats, under random
// stalls on both channels. The checker beside the block scores the results.
// ----------------------------------------------------------------------------
module icy_metadata_deframer_tb;
    import icymd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW          = DEF_INTERVAL_BITS;
    localparam int CYCLE_LIMIT = 400000;

    localparam int FLD_TITLE  = 0;
    localparam int FLD_URL    = 1;
    localparam int FLD_OTHER  = 2;
    localparam int FLD_EMPTY  = 3;
    localparam int FLD_BROKEN = 4;

    logic          aclk        = 1'b0;
    logic          aresetn     = 1'b0;
    logic          cfg_we      = 1'b0;
    logic [IW-1:0] cfg_wdata   = '0;
    logic          s_valid     = 1'b0;
    logic          s_ready;
    logic [7:0]    s_data_byte = 8'h00;
    logic          m_valid;
    logic          m_ready     = 1'b0;
    logic [2:0]    m_kind;
    logic [7:0]    m_value;
    logic          m_updated;
    logic          m_last;

    int mismatch_count;
    int deframed_left;
    int results_checked;

    logic [7:0] meta_buf [$];
    logic [7:0] prev_meta [$];
    int         prev_len     = -1;
    int         sent         = 0;
    int         settings     = 0;
    int         cur_interval = DEF_META_INTERVAL;
    int         aud_done     = 0;
    int         cycle_count  = 0;
    bit         no_idle      = 1'b0;
    bit         big_done     = 1'b0;

    always #2 aclk = ~aclk;

    icy_metadata_deframer dut (
        .aclk,
        .aresetn,
        .cfg_we,
        .cfg_wdata,
        .s_valid,
        .s_ready,
        .s_data_byte,
        .m_valid,
        .m_ready,
        .m_kind,
        .m_value,
        .m_updated,
        .m_last
    );

    icy_metadata_deframer_chk #(.IW(IW)) chk (
        .aclk,
        .aresetn,
        .cfg_we,
        .cfg_wdata,
        .s_valid,
        .s_ready,
        .s_data_byte,
        .m_valid,
        .m_ready,
        .m_kind,
        .m_value,
        .m_updated,
        .m_last,
        .mismatch_count,
        .deframed_left,
        .results_checked
    );

    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= 29);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     deframed_left);
            $display("Regression FAIL");
            $finish;
        end
    end

    // hold valid high across back-to-back requests; only drop it for a gap
    task automatic push_stream_byte(input logic [7:0] b);
        while (!no_idle && $urandom_range(0, 99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sent++;
    endtask

    // wait out every due result, then an extra wait for bytes that give none
    task automatic drain();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (deframed_left != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_interval(input logic [IW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        cur_interval = int'(v);
        settings++;
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            meta_buf.push_back(s[k]);
        end
    endtask

    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return CH_QUOTE;
        if (r < 20) return CH_SEMI;
        if (r < 30) return 8'($urandom_range(1, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic add_field(input int sel, input int nchars);
        string key;
        int    r;
        case (sel)
            FLD_TITLE: add_text("StreamTitle='");
            FLD_URL:   add_text("StreamUrl='");
            FLD_OTHER: begin
                if ($urandom_range(0, 1)) key = "StreamGenre='";
                else key = "icy-name='";
                add_text(key);
            end
            FLD_EMPTY: begin
                meta_buf.push_back(CH_SEMI);
                return;
            end
            default: begin
                // key cut short before its opening quote
                if ($urandom_range(0, 1)) key = "StreamTitle='";
                else key = "StreamUrl='";
                add_text(key.substr(0, $urandom_range(0, key.len() - 2)));
            end
        endcase
        repeat (nchars) meta_buf.push_back(text_byte());
        r = $urandom_range(0, 99);
        if (r < 80) begin
            add_text("';");
        end else if (r < 90) begin
            meta_buf.push_back(CH_QUOTE);
        end
    endtask

    // length byte, then 16*len_code content bytes padded past the buffer
    task automatic send_meta(input logic [7:0] len_code, input bit junk_tail);
        int total;
        total = 16 * len_code;
        push_stream_byte(len_code);
        for (int k = 0; k < total; k++) begin
            if (k < meta_buf.size()) begin
                push_stream_byte(meta_buf[k]);
            end else if (junk_tail) begin
                push_stream_byte(8'($urandom_range(1, 255)));
            end else begin
                push_stream_byte(8'h00);
            end
        end
    endtask

    initial begin
        int         r;
        int         sel;
        int         rand_start;
        logic [7:0] len_code;
        bit         junk;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset interval: plain audio at the byte extremes
        push_stream_byte(8'h00);
        push_stream_byte(8'hFF);
        drain();
        set_interval('1);
        push_stream_byte(8'h5A);
        drain();
        // interval now below the audio count: next byte is a zero length byte
        set_interval(IW'(2));
        push_stream_byte(8'h00);
        drain();
        set_interval(IW'(0));
        push_stream_byte(8'h00);
        // empty title, nonzero last byte
        meta_buf.delete();
        add_text("StreamTitle='';X");
        send_meta(1, 1'b0);
        // block again with another last byte: it still reads as zero
        meta_buf[15] = 8'h59;
        send_meta(1, 1'b0);
        // doubled quotes in a URL, a skipped field, a title cut off by block end
        meta_buf.delete();
        add_text("StreamUrl='''");
        meta_buf.push_back(8'hC3);
        add_text("';Z;StreamTitle='a");
        send_meta(2, 1'b0);

        rand_start = sent;
        while (sent - rand_start < 600) begin
            drain();
            r = $urandom_range(0, 99);
            if (r < 70) set_interval(IW'($urandom_range(1, 4)));
            else if (r < 90) set_interval(IW'($urandom_range(5, 24)));
            else set_interval(IW'(1));
            repeat ($urandom_range(3, 8)) begin
                while (aud_done < cur_interval) begin
                    push_stream_byte(8'($urandom));
                    aud_done++;
                end
                if (settings == 4 && !big_done) begin
                    // long block, no random stalls on either side
                    no_idle = 1'b1;
                    meta_buf.delete();
                    add_field(FLD_TITLE, 150);
                    add_field(FLD_URL, 120);
                    add_field(FLD_OTHER, 60);
                    send_meta(24, 1'b0);
                    no_idle  = 1'b0;
                    big_done = 1'b1;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 15 && prev_len >= 0) begin
                        meta_buf = prev_meta;
                        len_code = 8'(prev_len);
                        junk     = 1'b0;
                    end else begin
                        meta_buf.delete();
                        if (r < 80) begin
                            repeat ($urandom_range(1, 3)) begin
                                sel = $urandom_range(0, 99);
                                add_field(sel < 40 ? FLD_TITLE : sel < 70 ? FLD_URL :
                                          sel < 82 ? FLD_OTHER : sel < 90 ? FLD_EMPTY :
                                          FLD_BROKEN, $urandom_range(0, 10));
                            end
                            if ($urandom_range(0, 99) < 10) begin
                                meta_buf.push_back(8'h00);
                                repeat ($urandom_range(1, 6)) meta_buf.push_back(text_byte());
                            end
                        end else begin
                            repeat ($urandom_range(1, 40)) meta_buf.push_back(8'($urandom));
                        end
                        len_code = 8'((meta_buf.size() + 16) / 16);
                        if ($urandom_range(0, 99) < 10) begin
                            len_code = 8'((meta_buf.size() + 15) / 16);
                        end
                        junk      = ($urandom_range(0, 99) < 10);
                        prev_meta = meta_buf;
                        prev_len  = len_code;
                    end
                    send_meta(len_code, junk);
                end
                aud_done = 0;
            end
            // leave a partial audio run for the next interval to cut
            if ($urandom_range(0, 99) < 40) begin
                repeat ($urandom_range(1, cur_interval)) begin
                    push_stream_byte(8'($urandom));
                    aud_done++;
                end
            end
        end
        drain();

        $display("Stream of %0d bytes under %0d interval settings, blocks up to 385 bytes.",
                 sent, settings);
        $display("%0d results checked, %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0 && deframed_left == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
